### rtl/sorted_array_priority_queue_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted array priority queue
// Clocked implication helpers shared by the checker.
// ----------------------------------------------------------------------------
`ifndef SORTED_ARRAY_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_ARRAY_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SAPQ_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sapq: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SAPQ_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sapq: next-cycle check failed");

`endif

### rtl/sapq_pkg.sv
// ----------------------------------------------------------------------------
// sapq_pkg
// Types, sizes and helpers for the sorted array priority queue.
// ----------------------------------------------------------------------------
package sapq_pkg;

    localparam int CAPACITY     = 64;
    localparam int KEY_BITS     = 16;
    localparam int PAYLOAD_BITS = 16;
    localparam int CNT_BITS     = $clog2(CAPACITY + 1);
    localparam int TREE_FANIN   = 8;

    typedef enum logic [1:0] {
        REQ_ENQ  = 2'd0,
        REQ_DEQ  = 2'd1,
        REQ_PEEK = 2'd2,
        REQ_FIND = 2'd3
    } t_req_type;

    typedef struct packed {
        t_req_type               req_type;
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] payload;
    } t_req;

    typedef struct packed {
        logic                    ok;
        logic [KEY_BITS-1:0]     out_key;
        logic [PAYLOAD_BITS-1:0] out_payload;
        logic [CNT_BITS-1:0]     count;
    } t_rsp;

    typedef struct packed {
        logic enq;
        logic deq;
        logic find;
    } t_cell_ctl;

    // Width of a given level of the OR reduction tree.
    function automatic int tree_width(int w0, int lvl);
        int w;
        w = w0;
        for (int i = 0; i < lvl; i++) begin
            w = (w + TREE_FANIN - 1) / TREE_FANIN;
        end
        return w;
    endfunction

    // Number of registered levels needed to reduce w0 bits to one.
    function automatic int tree_levels(int w0);
        int w;
        int n;
        w = w0;
        n = 0;
        for (int i = 0; i < 32; i++) begin
            if (w > 1) begin
                w = (w + TREE_FANIN - 1) / TREE_FANIN;
                n = n + 1;
            end
        end
        if (n < 1) begin
            n = 1;
        end
        return n;
    endfunction

endpackage

### rtl/sapq_cell.sv
// ----------------------------------------------------------------------------
// sapq_cell
// One slot of the sorted chain: holds a key and payload, shifts down on
// insert, up on removal, and flags a key match for a find.
// ----------------------------------------------------------------------------
module sapq_cell #(
    parameter int KEY_BITS     = sapq_pkg::KEY_BITS,
    parameter int PAYLOAD_BITS = sapq_pkg::PAYLOAD_BITS
) (
    input  logic                    i_clk,
    input  sapq_pkg::t_cell_ctl     i_ctl,
    input  logic                    i_occ,
    input  logic [KEY_BITS-1:0]     i_new_key,
    input  logic [PAYLOAD_BITS-1:0] i_new_payload,
    input  logic                    i_above_held,
    input  logic [KEY_BITS-1:0]     i_above_key,
    input  logic [PAYLOAD_BITS-1:0] i_above_payload,
    input  logic [KEY_BITS-1:0]     i_below_key,
    input  logic [PAYLOAD_BITS-1:0] i_below_payload,
    output logic                    o_held,
    output logic [KEY_BITS-1:0]     o_key,
    output logic [PAYLOAD_BITS-1:0] o_payload,
    output logic                    o_match
);

    logic [KEY_BITS-1:0]     r_key;
    logic [KEY_BITS-1:0]     n_key;
    logic [PAYLOAD_BITS-1:0] r_payload;
    logic [PAYLOAD_BITS-1:0] n_payload;
    logic                    r_match;

    // Chain is descending from slot 0; strictly larger keys keep their place.
    assign o_held = i_occ && (r_key > i_new_key);

    always_comb begin
        n_key     = r_key;
        n_payload = r_payload;
        if (i_ctl.enq && !o_held) begin
            if (i_above_held) begin
                n_key     = i_new_key;
                n_payload = i_new_payload;
            end else begin
                n_key     = i_above_key;
                n_payload = i_above_payload;
            end
        end else if (i_ctl.deq) begin
            n_key     = i_below_key;
            n_payload = i_below_payload;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_payload <= n_payload;
        if (i_ctl.find) begin
            r_match <= i_occ && (r_key == i_new_key);
        end
    end

    assign o_key     = r_key;
    assign o_payload = r_payload;
    assign o_match   = r_match;

endmodule

### rtl/sapq_or_tree.sv
// ----------------------------------------------------------------------------
// sapq_or_tree
// Registered OR reduction of the per-slot match flags, each level in its own register.
// ----------------------------------------------------------------------------
module sapq_or_tree #(
    parameter int WIDTH = sapq_pkg::CAPACITY
) (
    input  logic             i_clk,
    input  logic [WIDTH-1:0] i_bits,
    output logic             o_any
);

    localparam int NLVL  = sapq_pkg::tree_levels(WIDTH);
    localparam int FANIN = sapq_pkg::TREE_FANIN;

    logic [WIDTH-1:0] r_lvl [NLVL];
    logic [WIDTH-1:0] n_lvl [NLVL];

    for (genvar l = 0; l < NLVL; l++) begin : g_lvl
        localparam int IW = sapq_pkg::tree_width(WIDTH, l);
        localparam int OW = sapq_pkg::tree_width(WIDTH, l + 1);

        logic [WIDTH-1:0] w_src;

        if (l == 0) begin : g_first
            assign w_src = i_bits;
        end else begin : g_next
            assign w_src = r_lvl[l-1];
        end

        always_comb begin
            n_lvl[l] = '0;
            for (int j = 0; j < OW; j++) begin
                for (int k = 0; k < FANIN; k++) begin
                    if (j * FANIN + k < IW) begin
                        n_lvl[l][j] = n_lvl[l][j] | w_src[j * FANIN + k];
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_lvl[l] <= n_lvl[l];
        end
    end

    assign o_any = r_lvl[NLVL-1][0];

endmodule

### rtl/sorted_array_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_array_priority_queue
// Fixed-capacity priority queue held in a chain of cells sorted by key,
// largest key (newest among equal keys) in cell 0.
// ----------------------------------------------------------------------------
//   channel   signals                      handshake
//   request   i_req (t_req)                transfer when start && !busy
//   result    o_rsp (t_rsp)                one-cycle strobe o_done, no stall
//
// Enqueue, dequeue and peek strobe their result in the cycle after the transfer
// and leave busy low, so one such request per cycle while no find holds busy.
// Find latches a match flag in every cell, then an OR tree of
// tree_levels(CAPACITY) registered levels (two at 64 entries) reduces them;
// busy stays high while the flags pass the tree; the result strobes as busy drops.
// Synchronous reset clears the count and the control; cell contents are not
// cleared and no sweep follows reset. Busy is high while reset is asserted.
// ----------------------------------------------------------------------------
module sorted_array_priority_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  sapq_pkg::t_req i_req,
    output logic           o_done,
    output sapq_pkg::t_rsp o_rsp
);

    localparam int CAPACITY  = sapq_pkg::CAPACITY;
    localparam int KB        = sapq_pkg::KEY_BITS;
    localparam int PB        = sapq_pkg::PAYLOAD_BITS;
    localparam int CB        = sapq_pkg::CNT_BITS;
    localparam int TREE_LVLS = sapq_pkg::tree_levels(CAPACITY);
    localparam int FCNT_BITS = $clog2(TREE_LVLS + 2);

    logic [CB-1:0]        r_count;
    logic [CB-1:0]        n_count;
    logic [FCNT_BITS-1:0] r_find_cnt;
    logic [FCNT_BITS-1:0] n_find_cnt;
    logic                 r_done;
    logic                 n_done;
    sapq_pkg::t_rsp       r_rsp;
    sapq_pkg::t_rsp       n_rsp;

    logic                 w_accept;
    logic                 w_full;
    logic                 w_empty;
    logic                 w_found;
    sapq_pkg::t_cell_ctl  w_ctl;

    logic [KB-1:0]        w_key   [CAPACITY];
    logic [PB-1:0]        w_pay   [CAPACITY];
    logic [CAPACITY-1:0]  w_held;
    logic [CAPACITY-1:0]  w_occ;
    logic [CAPACITY-1:0]  w_match;

    assign busy     = !i_rst_n || (r_find_cnt != '0);
    assign w_accept = start && !busy;
    assign w_full   = (r_count == CB'(CAPACITY));
    assign w_empty  = (r_count == '0);

    assign w_ctl.enq  = w_accept && (i_req.req_type == sapq_pkg::REQ_ENQ) && !w_full;
    assign w_ctl.deq  = w_accept && (i_req.req_type == sapq_pkg::REQ_DEQ) && !w_empty;
    assign w_ctl.find = w_accept && (i_req.req_type == sapq_pkg::REQ_FIND);

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic          w_above_held;
        logic [KB-1:0] w_above_key;
        logic [PB-1:0] w_above_pay;
        logic [KB-1:0] w_below_key;
        logic [PB-1:0] w_below_pay;

        assign w_occ[i] = (CB'(i) < r_count);

        if (i == 0) begin : g_head
            assign w_above_held = 1'b1;
            assign w_above_key  = '0;
            assign w_above_pay  = '0;
        end else begin : g_body
            assign w_above_held = w_held[i-1];
            assign w_above_key  = w_key[i-1];
            assign w_above_pay  = w_pay[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign w_below_key = w_key[i];
            assign w_below_pay = w_pay[i];
        end else begin : g_link
            assign w_below_key = w_key[i+1];
            assign w_below_pay = w_pay[i+1];
        end

        sapq_cell #(
            .KEY_BITS     (KB),
            .PAYLOAD_BITS (PB)
        ) u_cell (
            .i_clk           (i_clk),
            .i_ctl           (w_ctl),
            .i_occ           (w_occ[i]),
            .i_new_key       (i_req.key),
            .i_new_payload   (i_req.payload),
            .i_above_held    (w_above_held),
            .i_above_key     (w_above_key),
            .i_above_payload (w_above_pay),
            .i_below_key     (w_below_key),
            .i_below_payload (w_below_pay),
            .o_held          (w_held[i]),
            .o_key           (w_key[i]),
            .o_payload       (w_pay[i]),
            .o_match         (w_match[i])
        );
    end

    sapq_or_tree #(
        .WIDTH (CAPACITY)
    ) u_tree (
        .i_clk  (i_clk),
        .i_bits (w_match),
        .o_any  (w_found)
    );

    always_comb begin
        n_count = r_count;
        if (w_ctl.enq) begin
            n_count = r_count + CB'(1);
        end else if (w_ctl.deq) begin
            n_count = r_count - CB'(1);
        end
    end

    always_comb begin
        n_find_cnt = r_find_cnt;
        if (w_ctl.find) begin
            n_find_cnt = FCNT_BITS'(TREE_LVLS + 1);
        end else if (r_find_cnt != '0) begin
            n_find_cnt = r_find_cnt - FCNT_BITS'(1);
        end
    end

    always_comb begin
        n_done            = 1'b0;
        n_rsp.ok          = 1'b0;
        n_rsp.out_key     = '0;
        n_rsp.out_payload = '0;
        n_rsp.count       = n_count;
        if (w_accept) begin
            unique case (i_req.req_type) inside
                sapq_pkg::REQ_ENQ: begin
                    n_done   = 1'b1;
                    n_rsp.ok = !w_full;
                end
                sapq_pkg::REQ_DEQ, sapq_pkg::REQ_PEEK: begin
                    n_done = 1'b1;
                    if (!w_empty) begin
                        n_rsp.ok          = 1'b1;
                        n_rsp.out_key     = w_key[0];
                        n_rsp.out_payload = w_pay[0];
                    end
                end
                default: begin
                    // find: result comes from the reduction tree
                    n_done = 1'b0;
                end
            endcase
        end else if (r_find_cnt == FCNT_BITS'(1)) begin
            n_done   = 1'b1;
            n_rsp.ok = w_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_find_cnt <= '0;
            r_done     <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_find_cnt <= n_find_cnt;
            r_done     <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

### rtl/sapq_checker.sv
// ----------------------------------------------------------------------------
// sapq_checker
// Port-level checks on the priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "sorted_array_priority_queue_macros.svh"

module sapq_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input sapq_pkg::t_req i_req,
    input logic           o_done,
    input sapq_pkg::t_rsp o_rsp
);

    // A find completes in the cycle that busy drops.
    `SAPQ_ASSERT_IMP(a_find_done, i_clk, i_rst_n, $fell(busy) && $past(i_rst_n), o_done)

    // Every request other than find answers in the next cycle.
    `SAPQ_ASSERT_NXT(a_fast_done, i_clk, i_rst_n, start && !busy && (i_req.req_type != sapq_pkg::REQ_FIND), o_done)

    // The count never passes the capacity.
    `SAPQ_ASSERT_IMP(a_count_cap, i_clk, i_rst_n, o_done, o_rsp.count <= sapq_pkg::CNT_BITS'(sapq_pkg::CAPACITY))

    // A failed request returns no entry.
    `SAPQ_ASSERT_IMP(a_fail_zero, i_clk, i_rst_n, o_done && !o_rsp.ok, (o_rsp.out_key == '0) && (o_rsp.out_payload == '0))

endmodule

bind sorted_array_priority_queue sapq_checker u_sapq_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_req   (i_req),
    .o_done  (o_done),
    .o_rsp   (o_rsp)
);

### verif/tb_sorted_array_priority_queue.sv
// ----------------------------------------------------------------------------
// tb_sorted_array_priority_queue
// Self-checking bench for the sorted array priority queue. A directed opener
// covers empty and duplicate-key corners, then random phases fill the queue
// to capacity, drain it and mix requests. A behavioral copy of the queue
// predicts every response, and each response is checked field by field.
// ----------------------------------------------------------------------------
module tb_sorted_array_priority_queue;

    timeunit 1ns;
    timeprecision 1ps;

    import sapq_pkg::*;

    localparam int RANDOM_ITEMS   = 1400;
    localparam int PHASE_LEN      = 100;
    localparam int QUIET_FIRST    = 600;
    localparam int QUIET_LAST     = 900;
    localparam int IDLE_PCT       = 32;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_req i_req   = '0;
    logic busy;
    logic o_done;
    t_rsp o_rsp;

    // Behavioral copy of the queue, slot 0 holds the lowest key
    logic [KEY_BITS-1:0]     held_keys     [CAPACITY];
    logic [PAYLOAD_BITS-1:0] held_payloads [CAPACITY];
    int                      held = 0;

    t_req                req_backlog [$];
    t_rsp                rsp_expected [$];
    logic [KEY_BITS-1:0] enq_history [$];
    int                  total_reqs = 0;
    int                  accepted   = 0;
    int                  errors     = 0;
    int                  stall_cycles = 0;

    sorted_array_priority_queue dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    always #6 i_clk = ~i_clk;

    function automatic t_rsp apply_request(input t_req rq);
        t_rsp rsp;
        int   slot;
        rsp = '0;
        case (rq.req_type)
            REQ_ENQ: begin
                if (held < CAPACITY) begin
                    slot = held;
                    // shift larger keys up; equal keys stay below the new entry
                    while (slot > 0 && rq.key < held_keys[slot-1]) begin
                        held_keys[slot]     = held_keys[slot-1];
                        held_payloads[slot] = held_payloads[slot-1];
                        slot--;
                    end
                    held_keys[slot]     = rq.key;
                    held_payloads[slot] = rq.payload;
                    held++;
                    rsp.ok = 1'b1;
                end
            end
            REQ_DEQ, REQ_PEEK: begin
                if (held > 0) begin
                    rsp.ok          = 1'b1;
                    rsp.out_key     = held_keys[held-1];
                    rsp.out_payload = held_payloads[held-1];
                    if (rq.req_type == REQ_DEQ) begin
                        held--;
                    end
                end
            end
            default: begin
                for (int i = 0; i < held; i++) begin
                    if (held_keys[i] == rq.key) begin
                        rsp.ok = 1'b1;
                    end
                end
            end
        endcase
        rsp.count = CNT_BITS'(held);
        return rsp;
    endfunction

    task automatic add_req(input t_req_type op, input logic [KEY_BITS-1:0] k,
                           input logic [PAYLOAD_BITS-1:0] p);
        t_req rq;
        rq.req_type = op;
        rq.key      = k;
        rq.payload  = p;
        req_backlog.push_back(rq);
        if (op == REQ_ENQ) begin
            enq_history.push_back(k);
        end
    endtask

    function automatic logic [KEY_BITS-1:0] random_key();
        int unsigned roll;
        roll = $urandom_range(99);
        // narrow range breeds duplicates and find hits
        if (roll < 30) begin
            return KEY_BITS'($urandom_range(7));
        end else if (roll < 40) begin
            return $urandom_range(1) ? '1 : '0;
        end
        return KEY_BITS'($urandom);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        errors++;
    endtask

    initial begin
        int unsigned         roll;
        int                  phase;
        t_req_type           op;
        logic [KEY_BITS-1:0] k;

        // empty queue corners
        add_req(REQ_PEEK, 16'h0000, 16'h0000);
        add_req(REQ_DEQ,  16'hFFFF, 16'hFFFF);
        add_req(REQ_FIND, 16'h0000, 16'h0000);
        // extremes and a duplicated key
        add_req(REQ_ENQ,  16'h8000, 16'h1111);
        add_req(REQ_ENQ,  16'h8000, 16'h2222);
        add_req(REQ_ENQ,  16'h0000, 16'h0000);
        add_req(REQ_ENQ,  16'hFFFF, 16'hFFFF);
        add_req(REQ_ENQ,  16'h7FFF, 16'hAAAA);
        add_req(REQ_ENQ,  16'h5555, 16'h5555);
        add_req(REQ_FIND, 16'h8000, 16'h0000);
        add_req(REQ_FIND, 16'h1234, 16'hFFFF);
        add_req(REQ_FIND, 16'hFFFF, 16'h0000);
        add_req(REQ_FIND, 16'h0000, 16'h0000);
        add_req(REQ_PEEK, 16'hAAAA, 16'h5555);
        // drain: newest of the equal keys leaves first
        add_req(REQ_DEQ,  16'h0000, 16'h0000);
        add_req(REQ_DEQ,  16'h0000, 16'h0000);
        add_req(REQ_DEQ,  16'h0000, 16'h0000);
        add_req(REQ_PEEK, 16'h0000, 16'h0000);
        add_req(REQ_DEQ,  16'h0000, 16'h0000);
        add_req(REQ_DEQ,  16'h0000, 16'h0000);
        add_req(REQ_DEQ,  16'h0000, 16'h0000);
        add_req(REQ_DEQ,  16'h0000, 16'h0000);
        add_req(REQ_FIND, 16'h0000, 16'h0000);

        // phases rotate: fill to capacity, drain to empty, mixed
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            phase = (n / PHASE_LEN) % 3;
            roll  = $urandom_range(99);
            if (phase == 0) begin
                op = roll < 80 ? REQ_ENQ : roll < 85 ? REQ_DEQ :
                     roll < 93 ? REQ_PEEK : REQ_FIND;
            end else if (phase == 1) begin
                op = roll < 10 ? REQ_ENQ : roll < 85 ? REQ_DEQ :
                     roll < 92 ? REQ_PEEK : REQ_FIND;
            end else begin
                op = roll < 40 ? REQ_ENQ : roll < 70 ? REQ_DEQ :
                     roll < 85 ? REQ_PEEK : REQ_FIND;
            end
            if (op == REQ_FIND && enq_history.size() > 0 && $urandom_range(1) == 1) begin
                k = enq_history[$urandom_range(enq_history.size() - 1)];
            end else begin
                k = random_key();
            end
            add_req(op, k, PAYLOAD_BITS'($urandom));
        end
        total_reqs = req_backlog.size();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted < total_reqs || rsp_expected.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Driver: hold the request until the transfer, then load the next one
    always @(posedge i_clk) begin
        logic fired;
        logic hold_off;
        fired = 1'b0;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                rsp_expected.push_back(apply_request(i_req));
                accepted++;
                fired = 1'b1;
            end
            if (!start || fired) begin
                hold_off = (accepted < QUIET_FIRST || accepted >= QUIET_LAST) &&
                           ($urandom_range(99) < IDLE_PCT);
                if (req_backlog.size() > 0 && !hold_off) begin
                    start <= 1'b1;
                    i_req <= req_backlog.pop_front();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each strobed response with the oldest prediction
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_done) begin
            if (rsp_expected.size() == 0) begin
                report_mismatch("response with no request outstanding");
            end else begin
                want = rsp_expected.pop_front();
                if (o_rsp.ok !== want.ok) begin
                    report_mismatch($sformatf("ok: got %b, want %b", o_rsp.ok, want.ok));
                end
                if (o_rsp.out_key !== want.out_key) begin
                    report_mismatch($sformatf("out_key: got %h, want %h",
                                              o_rsp.out_key, want.out_key));
                end
                if (o_rsp.out_payload !== want.out_payload) begin
                    report_mismatch($sformatf("out_payload: got %h, want %h",
                                              o_rsp.out_payload, want.out_payload));
                end
                if (o_rsp.count !== want.count) begin
                    report_mismatch($sformatf("count: got %0d, want %0d",
                                              o_rsp.count, want.count));
                end
            end
        end
    end

    // Watchdog: give up after a long run of cycles with no transfer or response
    always @(posedge i_clk) begin
        if ((i_rst_n && start && !busy) || (i_rst_n && o_done)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired after %0d idle cycles", stall_cycles);
            $display("Test completed with failures");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule
